/* hw/rtl/sbpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap page directory: shared definitions
// Word geometry of the occupancy bitmap, action and status codes, register
// indexes and reset values, and the summary that the word unit returns.
// ----------------------------------------------------------------------------
package sbpd_pkg;

  // Bitmap word geometry.
  localparam int WORD_W = 64;
  localparam int POS_W  = $clog2(WORD_W);
  localparam int CNT_W  = POS_W + 1;

  // Width of the serial divider operands.
  localparam int DIV_W = 16;

  // Action codes.
  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_MARK  = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_CHECK = 3'd3;
  localparam logic [2:0] ACT_COUNT = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Register indexes and reset values.
  localparam logic REG_PAGE   = 1'b0;
  localparam logic REG_RECORD = 1'b1;
  localparam logic [15:0] PAGE_RESET   = 16'd4096;
  localparam logic [15:0] RECORD_RESET = 16'd64;

  // Summary of one bitmap word under the capacity mask.
  typedef struct packed {
    logic             free_any;
    logic [POS_W-1:0] free_pos;
    logic [CNT_W-1:0] used_cnt;
  } word_info_t;

endpackage
`default_nettype wire

/* hw/rtl/sbpd_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap page directory: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbpd_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [sbpd_pkg::DIV_W-1:0] dividend,
  input  wire logic [sbpd_pkg::DIV_W-1:0] divisor,
  output logic                            done,
  output logic      [sbpd_pkg::DIV_W-1:0] quot
);
  import sbpd_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, d_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt   = dividend;
      d_nxt   = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? DIV_W'(shifted - {1'b0, d_r}) : shifted[DIV_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

/* hw/rtl/sbpd_bitmap_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap page directory: bitmap memory
// One write port and one registered read port over the occupancy words.
// ----------------------------------------------------------------------------
module sbpd_bitmap_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [sbpd_pkg::WORD_W-1:0] wr_data,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [sbpd_pkg::WORD_W-1:0] rd_data
);
  import sbpd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* hw/rtl/sbpd_word_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap page directory: word unit
// Finds the lowest free slot and counts the used slots of one bitmap word,
// looking only at the bits that the capacity mask admits.
// ----------------------------------------------------------------------------
module sbpd_word_unit (
  input  wire logic [sbpd_pkg::WORD_W-1:0] word,
  input  wire logic [sbpd_pkg::WORD_W-1:0] mask,
  output sbpd_pkg::word_info_t             info
);
  import sbpd_pkg::*;

  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] used_bits;

  assign free_bits = ~word & mask;
  assign used_bits = word & mask;

  always_comb begin
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    pos = '0;
    cnt = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = POS_W'(i);
      end
    end
    for (int i = 0; i < WORD_W; i++) begin
      cnt = cnt + CNT_W'(used_bits[i]);
    end
    info.free_any = |free_bits;
    info.free_pos = pos;
    info.used_cnt = cnt;
  end

endmodule
`default_nettype wire

/* hw/rtl/slot_bitmap_page_directory_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap page directory
// Occupancy bitmap of a page of fixed-length records, with allocate, mark,
// free, check, count and clear actions under a small sequencer.
// ----------------------------------------------------------------------------
// Allocate scans the bitmap words upward from word 0 and stops at the first free slot; it reports
// full once every word below capacity has been seen. Mark, free and check read the word of the slot,
// which mark and free then update; out of range they respond at once. Count responds at once, and
// clear writes every word. One action is in work at a time and the next start is taken once busy
// falls; the receiver cannot stall the result. Reset runs a clearing pass over every word, then a
// recount of the capacity, as each register write does; busy stays high meanwhile.
module slot_bitmap_page_directory_top #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [9:0]  in_slot_index,
  // Result channel.
  output logic             out_valid,
  output logic      [9:0]  out_result_slot,
  output logic      [15:0] out_byte_offset,
  output logic      [1:0]  out_status,
  output logic      [10:0] out_free_slots,
  output logic      [10:0] out_slot_capacity,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import sbpd_pkg::*;

  // Bitmap geometry derived from the slot limit.
  localparam int NW   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CAPW = $clog2(MAX_SLOTS + 1);
  localparam int IXW  = (CAPW > 10) ? CAPW : 10;
  localparam int FW   = IXW - POS_W;
  localparam int PTRW = FW + 1;
  localparam logic [16:0]     MAX_CAP   = 17'(MAX_SLOTS);
  localparam logic [PTRW-1:0] LAST_WORD = PTRW'(NW - 1);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_DIV1  = 9'b000000100,
    S_DIV2  = 9'b000001000,
    S_CNT   = 9'b000010000,
    S_ALLOC = 9'b000100000,
    S_RD    = 9'b001000000,
    S_MOD   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  // Control registers.
  state_t          state_r, state_nxt;
  logic [PTRW-1:0] ptr_r, ptr_nxt;
  logic            dv_r, dv_nxt;
  logic            rc_pend_r, rc_pend_nxt;
  logic            clr_rst_r, clr_rst_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     page_r, page_nxt;
  logic [15:0]     rec_r, rec_nxt;
  logic [CAPW-1:0] cap_r, cap_nxt;
  logic [CAPW-1:0] used_r, used_nxt;

  // Payload registers.
  logic [AW-1:0]   daddr_r, daddr_nxt;
  logic [2:0]      act_r, act_nxt;
  logic [IXW-1:0]  slot_r, slot_nxt;
  logic [IXW-1:0]  res_slot_r, res_slot_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            offs_en_r, offs_en_nxt;
  logic [9:0]      o_slot_r, o_slot_nxt;
  logic [15:0]     o_offs_r, o_offs_nxt;
  logic [1:0]      o_status_r, o_status_nxt;
  logic [10:0]     o_free_r, o_free_nxt;
  logic [10:0]     o_cap_r, o_cap_nxt;

  // Datapath signals.
  logic              cfg_wr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] cap_mask;
  word_info_t        winfo;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W-1:0]  dir_bytes;
  logic [16:0]       q_ext;
  logic [16:0]       cap_clamp;
  logic              cap_zero;
  logic [IXW-1:0]    cap_x;
  logic [FW-1:0]     cap_full;
  logic [POS_W-1:0]  cap_part;
  logic [PTRW-1:0]   cap_words;
  logic              ptr_lt;
  logic [FW-1:0]     daddr_x;
  logic [IXW-1:0]    slot_x;
  logic [15:0]       offs_lo;
  logic              cur_bit;
  logic [WORD_W-1:0] slot_hot;
  logic [WORD_W-1:0] alloc_hot;

  // The configuration port never waits; reads return the stored registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_RECORD) ? {16'd0, rec_r} : {16'd0, page_r};

  // Capacity split into whole words and the bits of a partial last word.
  assign cap_x     = IXW'(cap_r);
  assign cap_full  = cap_x[IXW-1:POS_W];
  assign cap_part  = cap_x[POS_W-1:0];
  assign cap_words = PTRW'(cap_full) + PTRW'(cap_part != '0);
  assign ptr_lt    = ptr_r < cap_words;

  // Mask of the slots below capacity in the word whose data is now returned.
  assign daddr_x = FW'(daddr_r);
  always_comb begin
    if (daddr_x < cap_full) begin
      cap_mask = '1;
    end else if (daddr_x == cap_full) begin
      cap_mask = (WORD_W'(1) << cap_part) - WORD_W'(1);
    end else begin
      cap_mask = '0;
    end
  end

  // Capacity arithmetic: the first division gives the slot count of the bare
  // page, the second the count once the directory bytes are taken off.
  assign cap_zero     = (rec_r == '0) || (rec_r >= page_r);
  assign dir_bytes    = DIV_W'((17'(div_q) + 17'd7) >> 3);
  assign div_dividend = (state_r == S_DIV1) ? (page_r - dir_bytes) : page_r;
  assign q_ext        = {1'b0, div_q};
  assign cap_clamp    = (q_ext > MAX_CAP) ? MAX_CAP : q_ext;

  assign slot_x    = IXW'(in_slot_index);
  assign cur_bit   = rd_data[slot_r[POS_W-1:0]];
  assign slot_hot  = WORD_W'(1) << slot_r[POS_W-1:0];
  assign alloc_hot = WORD_W'(1) << winfo.free_pos;
  assign offs_lo   = 16'(res_slot_r) * rec_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    dv_nxt        = dv_r;
    rc_pend_nxt   = rc_pend_r;
    clr_rst_nxt   = clr_rst_r;
    out_valid_nxt = 1'b0;
    page_nxt      = page_r;
    rec_nxt       = rec_r;
    cap_nxt       = cap_r;
    used_nxt      = used_r;
    daddr_nxt     = daddr_r;
    act_nxt       = act_r;
    slot_nxt      = slot_r;
    res_slot_nxt  = res_slot_r;
    status_nxt    = status_r;
    offs_en_nxt   = offs_en_r;
    o_slot_nxt    = o_slot_r;
    o_offs_nxt    = o_offs_r;
    o_status_nxt  = o_status_r;
    o_free_nxt    = o_free_r;
    o_cap_nxt     = o_cap_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r[AW-1:0];
    wr_data       = '0;
    rd_addr       = ptr_r[AW-1:0];
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          // The recount waits until the register write has landed.
        end else if (rc_pend_r) begin
          rc_pend_nxt = 1'b0;
          ptr_nxt     = '0;
          dv_nxt      = 1'b0;
          used_nxt    = '0;
          if (cap_zero) begin
            cap_nxt   = '0;
            state_nxt = S_CNT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV1;
          end
        end else if (start) begin
          act_nxt  = in_action;
          slot_nxt = slot_x;
          ptr_nxt  = '0;
          dv_nxt   = 1'b0;
          case (in_action)
            ACT_ALLOC: begin
              state_nxt = S_ALLOC;
            end
            ACT_MARK, ACT_FREE, ACT_CHECK: begin
              res_slot_nxt = slot_x;
              if (slot_x >= cap_x) begin
                status_nxt  = ST_RANGE;
                offs_en_nxt = 1'b0;
                state_nxt   = S_RESP;
              end else begin
                status_nxt  = ST_OK;
                offs_en_nxt = 1'b1;
                state_nxt   = S_RD;
              end
            end
            ACT_CLEAR: begin
              clr_rst_nxt = 1'b0;
              state_nxt   = S_CLR;
            end
            default: begin
              // Count and the unused codes change nothing.
              res_slot_nxt = '0;
              status_nxt   = ST_OK;
              offs_en_nxt  = 1'b0;
              state_nxt    = S_RESP;
            end
          endcase
        end
      end

      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = '0;
        if (ptr_r == LAST_WORD) begin
          if (clr_rst_r) begin
            state_nxt = S_IDLE;
          end else begin
            used_nxt     = '0;
            res_slot_nxt = '0;
            status_nxt   = ST_OK;
            offs_en_nxt  = 1'b0;
            state_nxt    = S_RESP;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV2;
        end
      end

      S_DIV2: begin
        if (div_done) begin
          cap_nxt   = cap_clamp[CAPW-1:0];
          state_nxt = S_CNT;
        end
      end

      S_CNT: begin
        if (dv_r) begin
          used_nxt = used_r + CAPW'(winfo.used_cnt);
        end
        dv_nxt    = ptr_lt;
        daddr_nxt = ptr_r[AW-1:0];
        if (ptr_lt) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (!dv_r && !ptr_lt) begin
          state_nxt = S_IDLE;
        end
      end

      S_ALLOC: begin
        dv_nxt    = ptr_lt;
        daddr_nxt = ptr_r[AW-1:0];
        if (ptr_lt) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (dv_r && winfo.free_any) begin
          wr_en        = 1'b1;
          wr_addr      = daddr_r;
          wr_data      = rd_data | alloc_hot;
          res_slot_nxt = IXW'({daddr_r, winfo.free_pos});
          status_nxt   = ST_OK;
          offs_en_nxt  = 1'b1;
          used_nxt     = used_r + 1'b1;
          state_nxt    = S_RESP;
        end else if (!dv_r && !ptr_lt) begin
          // Every word below capacity has been seen without a free slot.
          res_slot_nxt = '0;
          status_nxt   = ST_FULL;
          offs_en_nxt  = 1'b0;
          state_nxt    = S_RESP;
        end
      end

      S_RD: begin
        rd_addr   = slot_r[POS_W +: AW];
        state_nxt = S_MOD;
      end

      S_MOD: begin
        wr_addr = slot_r[POS_W +: AW];
        case (act_r)
          ACT_MARK: begin
            if (!cur_bit) begin
              wr_en    = 1'b1;
              wr_data  = rd_data | slot_hot;
              used_nxt = used_r + 1'b1;
            end
          end
          ACT_FREE: begin
            if (cur_bit) begin
              wr_en    = 1'b1;
              wr_data  = rd_data & ~slot_hot;
              used_nxt = used_r - 1'b1;
            end
          end
          default: begin
            status_nxt = cur_bit ? ST_OK : ST_EMPTY;
          end
        endcase
        state_nxt = S_RESP;
      end

      S_RESP: begin
        out_valid_nxt = 1'b1;
        o_slot_nxt    = 10'(res_slot_r);
        o_offs_nxt    = offs_en_r ? offs_lo : 16'd0;
        o_status_nxt  = status_r;
        o_free_nxt    = 11'(cap_r - used_r);
        o_cap_nxt     = 11'(cap_r);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write lands now and forces a fresh recount; one that
    // arrives during a recount abandons it and starts over from idle.
    if (cfg_wr) begin
      rc_pend_nxt = 1'b1;
      if (paddr[2] == REG_RECORD) begin
        rec_nxt = pwdata[15:0];
      end else begin
        page_nxt = pwdata[15:0];
      end
      if (state_r == S_DIV1 || state_r == S_DIV2 || state_r == S_CNT) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      rc_pend_r   <= 1'b1;
      clr_rst_r   <= 1'b1;
      out_valid_r <= 1'b0;
      page_r      <= PAGE_RESET;
      rec_r       <= RECORD_RESET;
      cap_r       <= '0;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      rc_pend_r   <= rc_pend_nxt;
      clr_rst_r   <= clr_rst_nxt;
      out_valid_r <= out_valid_nxt;
      page_r      <= page_nxt;
      rec_r       <= rec_nxt;
      cap_r       <= cap_nxt;
      used_r      <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    daddr_r    <= daddr_nxt;
    act_r      <= act_nxt;
    slot_r     <= slot_nxt;
    res_slot_r <= res_slot_nxt;
    status_r   <= status_nxt;
    offs_en_r  <= offs_en_nxt;
    o_slot_r   <= o_slot_nxt;
    o_offs_r   <= o_offs_nxt;
    o_status_r <= o_status_nxt;
    o_free_r   <= o_free_nxt;
    o_cap_r    <= o_cap_nxt;
  end

  // Busy covers the sequencer, a pending recount and a write in flight.
  assign busy = (state_r != S_IDLE) | rc_pend_r | cfg_wr;

  assign out_valid         = out_valid_r;
  assign out_result_slot   = o_slot_r;
  assign out_byte_offset   = o_offs_r;
  assign out_status        = o_status_r;
  assign out_free_slots    = o_free_r;
  assign out_slot_capacity = o_cap_r;

  sbpd_bitmap_ram #(
    .DEPTH (NW),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbpd_word_unit u_word (
    .word (rd_data),
    .mask (cap_mask),
    .info (winfo)
  );

  sbpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rec_r),
    .done     (div_done),
    .quot     (div_q)
  );

endmodule
`default_nettype wire
